/* hw/rtl/radix_converter_macros.svh */
// Assertion macros for the radix converter.
// Included by the top level; each macro expects signals named clock and reset in scope.
`ifndef RADIX_CONVERTER_MACROS_SVH
`define RADIX_CONVERTER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RC_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* hw/rtl/rc_pkg.sv */
// Shared types, constants and helper functions of the radix converter.
// No dependencies; rc_div_unit, rc_lifo and the top level refer to it by scoped names.
package rc_pkg;

   // Field widths.
   localparam int WORD_W      = 31;
   localparam int BASE_W      = 6;
   localparam int CHAR_W      = 7;
   localparam int DEC_DIGIT_W = 4;
   localparam int DEC_DIGITS  = 10;
   localparam int DEC_CNT_W   = 4;
   localparam int VALUE_W     = 64;
   localparam int CSR_INDEX_W = 1;

   // Default depth of the result digit store.
   localparam int DEFAULT_MAX_DIGITS = 64;

   // Arithmetic constants.
   localparam logic [BASE_W-1:0] DEC_RADIX      = 6'd10;
   localparam logic [BASE_W-1:0] BASE_CAP       = 6'd36;
   localparam logic [BASE_W-1:0] SRC_BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] TGT_BASE_RESET = 6'd2;
   localparam logic [CHAR_W-1:0] ASCII_ZERO     = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_LETTER   = 7'd55;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_BASE = 1'b0,
      CSR_TARGET_BASE = 1'b1
   } csr_index_type;

   // Payload of one input item and one result item.
   typedef struct packed {
      logic [WORD_W-1:0] digit_word;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } rsp_payload_type;

   // Control of a digit stack.
   typedef struct packed {
      logic push;
      logic pop;
   } lifo_ctl_type;

   // Bases above the cap behave as the cap.
   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
      return (b > BASE_CAP) ? BASE_CAP : b;
   endfunction

   // Digit value to its ASCII character.
   function automatic logic [CHAR_W-1:0] to_ascii(input logic [BASE_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = {1'b0, d};
      return (d < DEC_RADIX) ? (wide + ASCII_ZERO) : (wide + ASCII_LETTER);
   endfunction

endpackage

/* hw/rtl/rc_stream_if.sv */
// Valid/ready stream interface used for the item channels of the radix converter.
// The payload type is handed in by the instantiating level, usually a struct of rc_pkg.
interface rc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rc_div_unit.sv */
// Shared divide unit: one byte of a long division by a small divisor per cycle.
// Depends on rc_pkg for widths; used for both the decimal split and the target conversion.
module rc_div_unit (
   input  logic [7:0]               chunk,
   input  logic [rc_pkg::BASE_W-1:0] rem_prev,
   input  logic [rc_pkg::BASE_W-1:0] divisor,
   output logic [7:0]               quot,
   output logic [rc_pkg::BASE_W-1:0] rem_next
);

   // Eight restoring steps, most significant bit of the chunk first.
   // The running remainder stays below the divisor, so it fits the base width.
   always_comb begin
      logic [rc_pkg::BASE_W:0]   part;
      logic [rc_pkg::BASE_W-1:0] r;
      r    = rem_prev;
      quot = '0;
      part = '0;
      for (int i = 7; i >= 0; i--) begin
         part = {r, chunk[i]};
         if (part >= {1'b0, divisor}) begin
            quot[i] = 1'b1;
            r       = rc_pkg::BASE_W'(part - {1'b0, divisor});
         end else begin
            r = part[rc_pkg::BASE_W-1:0];
         end
      end
      rem_next = r;
   end

endmodule

/* hw/rtl/rc_lifo.sv */
// Digit stack: the top entry sits in a register, the entries beneath it in an array.
// Depends on rc_pkg for the control struct; holds decimal digits or result digits.
module rc_lifo #(
   parameter int WIDTH = rc_pkg::BASE_W,
   parameter int DEPTH = rc_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rc_pkg::lifo_ctl_type ctl,
   input  logic [WIDTH-1:0]     din,
   output logic [WIDTH-1:0]     top
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  stack_mem [DEPTH];
   logic [WIDTH-1:0]  top_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // The old top goes one slot below the count; a pop reads the entry under it.
   assign wr_addr = ADDR_W'(count_ff - CNT_W'(1));
   assign rd_addr = ADDR_W'(count_ff - CNT_W'(2));

   // Occupancy count.
   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload storage needs no reset; one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         top_ff <= din;
         if (count_ff != '0) begin
            stack_mem[wr_addr] <= top_ff;
         end
      end else if (ctl.pop) begin
         if (count_ff > CNT_W'(1)) begin
            top_ff <= stack_mem[rd_addr];
         end
      end
   end

   assign top = top_ff;

endmodule

/* hw/rtl/radix_converter.sv */
// Top level of the radix converter: sequencer, value register and the two digit stacks.
// Depends on rc_pkg, rc_stream_if, rc_div_unit, rc_lifo and radix_converter_macros.svh.
//
//   port         dir   kind                what it moves
//   req_chan     in    valid/ready stream  one item: digit_word
//   rsp_chan     out   valid/ready stream  one digit per item: digit_char, last
//   csr_*        in    write port          source_base (index 0), target_base (index 1)
//
// An item is taken only while the block is idle; it is then busy until its last digit leaves.
// Each item is accepted, split into decimal digits by repeated division by ten, one byte of
// the word at a time, weighted back in by the source base, most significant digit first,
// divided repeatedly by the target base, one byte of the running quotient at a time, both
// divisions through the byte-wide shared divide unit, and then emitted digit by digit.
// A degenerate base or a zero word goes straight to one '0' result. Reset is synchronous.
// A stalled rsp_chan holds the current digit; no further work is done meanwhile.
`include "radix_converter_macros.svh"

module radix_converter #(
   parameter int MAX_DIGITS = rc_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                           clock,
   input  logic                           reset,
   rc_stream_if.sink                      req_chan,
   rc_stream_if.source                    rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [rc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rc_pkg::BASE_W-1:0]      csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DEC    = 5'b00010,
      ST_HORNER = 5'b00100,
      ST_CONV   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   // Number of significant bytes of a 64-bit value, 0 when it is zero.
   function automatic logic [3:0] byte_len(input logic [rc_pkg::VALUE_W-1:0] v);
      logic [3:0] len;
      len = '0;
      for (int i = 0; i < 8; i++) begin
         if (v[i*8 +: 8] != 8'd0) begin
            len = 4'(i + 1);
         end
      end
      return len;
   endfunction

   state_type                         state_ff, state_in;
   logic [rc_pkg::BASE_W-1:0]         src_base_ff, src_base_in;
   logic [rc_pkg::BASE_W-1:0]         tgt_base_ff, tgt_base_in;
   logic [rc_pkg::VALUE_W-1:0]        acc_ff, acc_in;
   logic [rc_pkg::BASE_W-1:0]         rem_ff, rem_in;
   logic [2:0]                        idx_ff, idx_in;
   logic [rc_pkg::DEC_CNT_W-1:0]      dcount_ff, dcount_in;
   logic [CNT_W-1:0]                  ocount_ff, ocount_in;

   logic [rc_pkg::BASE_W-1:0]         src_c, tgt_c, divisor;
   logic [7:0]                        chunk, quot;
   logic [rc_pkg::BASE_W-1:0]         rem_next;
   logic [rc_pkg::VALUE_W-1:0]        acc_quot, word_ext;
   logic [rc_pkg::VALUE_W+rc_pkg::BASE_W-1:0] mac_full;
   logic [3:0]                        quot_len, word_len, acc_len;
   logic                              degenerate, in_fire, out_fire;

   rc_pkg::lifo_ctl_type              dec_ctl, out_ctl;
   logic [rc_pkg::DEC_DIGIT_W-1:0]    dec_top;
   logic [rc_pkg::BASE_W-1:0]         out_din, out_top;

   // Configuration registers; the user must change the bases only while idle; this is not enforced.
   always_comb begin
      src_base_in = src_base_ff;
      tgt_base_in = tgt_base_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rc_pkg::CSR_SOURCE_BASE: src_base_in = csr_wr_data;
            rc_pkg::CSR_TARGET_BASE: tgt_base_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   assign src_c      = rc_pkg::clamp_base(src_base_ff);
   assign tgt_c      = rc_pkg::clamp_base(tgt_base_ff);
   assign degenerate = (src_c < 6'd2) || (tgt_c < 6'd2);

   // Shared divide unit: by ten while splitting the word, by the target base afterwards.
   assign divisor = (state_ff == ST_DEC) ? rc_pkg::DEC_RADIX : tgt_c;
   assign chunk   = acc_ff[{idx_ff, 3'b000} +: 8];

   rc_div_unit u_div (
      .chunk    (chunk),
      .rem_prev (rem_ff),
      .divisor  (divisor),
      .quot     (quot),
      .rem_next (rem_next)
   );

   // Quotient byte goes back where its dividend byte came from.
   always_comb begin
      acc_quot = acc_ff;
      acc_quot[{idx_ff, 3'b000} +: 8] = quot;
   end

   assign word_ext = rc_pkg::VALUE_W'(req_chan.data.digit_word);
   assign quot_len = byte_len(acc_quot);
   assign word_len = byte_len(word_ext);
   assign acc_len  = byte_len(acc_ff);
   assign mac_full = acc_ff * src_c;

   // Decimal digit stack and result digit stack.
   rc_lifo #(
      .WIDTH (rc_pkg::DEC_DIGIT_W),
      .DEPTH (rc_pkg::DEC_DIGITS)
   ) u_dec_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (dec_ctl),
      .din   (rem_next[rc_pkg::DEC_DIGIT_W-1:0]),
      .top   (dec_top)
   );

   rc_lifo #(
      .WIDTH (rc_pkg::BASE_W),
      .DEPTH (MAX_DIGITS)
   ) u_out_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (out_ctl),
      .din   (out_din),
      .top   (out_top)
   );

   assign in_fire  = req_chan.valid && req_chan.ready;
   assign out_fire = rsp_chan.valid && rsp_chan.ready;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      dcount_in = dcount_ff;
      ocount_in = ocount_ff;
      dec_ctl   = '0;
      out_ctl   = '0;
      out_din   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_fire) begin
               rem_in    = '0;
               dcount_in = '0;
               if (degenerate || (word_len == 4'd0)) begin
                  // Single '0' result.
                  out_ctl.push = 1'b1;
                  ocount_in    = CNT_W'(1);
                  state_in     = ST_EMIT;
               end else begin
                  acc_in   = word_ext;
                  idx_in   = 3'(word_len - 4'd1);
                  state_in = ST_DEC;
               end
            end
         end
         ST_DEC: begin
            acc_in = acc_quot;
            rem_in = rem_next;
            idx_in = idx_ff - 3'd1;
            if (idx_ff == 3'd0) begin
               // End of a pass: the remainder is the next decimal digit.
               dec_ctl.push = 1'b1;
               dcount_in    = dcount_ff + rc_pkg::DEC_CNT_W'(1);
               rem_in       = '0;
               if (quot_len == 4'd0) begin
                  state_in = ST_HORNER;
               end else begin
                  idx_in = 3'(quot_len - 4'd1);
               end
            end
         end
         ST_HORNER: begin
            if (dcount_ff != '0) begin
               // Weight in one decimal digit, most significant first.
               acc_in      = mac_full[rc_pkg::VALUE_W-1:0] + rc_pkg::VALUE_W'(dec_top);
               dec_ctl.pop = 1'b1;
               dcount_in   = dcount_ff - rc_pkg::DEC_CNT_W'(1);
            end else if (acc_len == 4'd0) begin
               out_ctl.push = 1'b1;
               ocount_in    = CNT_W'(1);
               state_in     = ST_EMIT;
            end else begin
               rem_in   = '0;
               idx_in   = 3'(acc_len - 4'd1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            acc_in = acc_quot;
            rem_in = rem_next;
            idx_in = idx_ff - 3'd1;
            if (idx_ff == 3'd0) begin
               // End of a pass: the remainder is the next target digit.
               out_ctl.push = 1'b1;
               out_din      = rem_next;
               ocount_in    = ocount_ff + CNT_W'(1);
               rem_in       = '0;
               if ((quot_len == 4'd0) || (ocount_ff == CNT_W'(MAX_DIGITS - 1))) begin
                  state_in = ST_EMIT;
               end else begin
                  idx_in = 3'(quot_len - 4'd1);
               end
            end
         end
         ST_EMIT: begin
            if (out_fire) begin
               out_ctl.pop = 1'b1;
               ocount_in   = ocount_ff - CNT_W'(1);
               if (ocount_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         src_base_ff <= rc_pkg::SRC_BASE_RESET;
         tgt_base_ff <= rc_pkg::TGT_BASE_RESET;
         idx_ff      <= '0;
         dcount_ff   <= '0;
         ocount_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         src_base_ff <= src_base_in;
         tgt_base_ff <= tgt_base_in;
         idx_ff      <= idx_in;
         dcount_ff   <= dcount_in;
         ocount_ff   <= ocount_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   // Handshake and result payload.
   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = (state_ff == ST_EMIT);
   assign rsp_chan.data.digit_char = rc_pkg::to_ascii(out_top);
   assign rsp_chan.data.last       = (ocount_ff == CNT_W'(1));

   // Checks.
   `RC_ASSERT_IMPL(a_no_overlap, rsp_chan.valid, !req_chan.ready, "result offered while input open")
   `RC_ASSERT_NEXT(a_busy_after_accept, in_fire, !req_chan.ready, "ready right after accept")
   `RC_ASSERT_NEXT(a_idle_after_last, out_fire && rsp_chan.data.last, req_chan.ready, "busy after last")
   `RC_ASSERT_IMPL(a_emit_count, state_ff == ST_EMIT, ocount_ff != '0, "emitting from an empty stack")

endmodule
